/* rtl/hcr_pkg.sv */
// Shared types, colour tables and segment reciprocals for the height colour ramp
package hcr_pkg;

    // Transaction payloads
    typedef struct packed {
        logic [15:0] height;
        logic [15:0] water_depth;
        logic [15:0] ice_thickness;
        logic [15:0] snow_depth;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_out_item;

    // Palette selector codes; the unused code falls back to terrain
    typedef enum logic [1:0] {
        PRE_TERRAIN = 2'd0,
        PRE_GRAY    = 2'd1,
        PRE_ELEV    = 2'd2
    } t_preset;

    // Cell class, in priority order
    typedef enum logic [1:0] {
        CLS_ICE,
        CLS_SNOW,
        CLS_WATER,
        CLS_TERRAIN
    } t_cls;

    // Colour triple, index 0 is red
    typedef logic [0:2][7:0] t_rgb;

    // Per-stage load enables handed to each channel lane
    typedef struct packed {
        logic ld3;
        logic ld4;
        logic ld5;
    } t_lane_en;

    // One ramp segment: start position, span less one, reciprocal, end colours
    typedef struct packed {
        logic [15:0] lo_pos;
        logic [15:0] den_m1;
        logic [31:0] rcp;
        t_rgb        lo;
        t_rgb        hi;
    } t_seg;

    localparam int         CHAN_W    = 8;
    localparam int         NUM_W     = 16;
    localparam int         PROD_W    = 25;   // diff * num plus ceiling bias
    localparam int         RCP_W     = 32;
    localparam int         RCP_SHIFT = 42;
    localparam int         MUL_W     = PROD_W + RCP_W;
    localparam logic [63:0] RCP_ONE  = 64'd1 << RCP_SHIFT;

    // Overlay thresholds and gains (Q4.12 depths)
    localparam logic [15:0] ICE_MIN    = 16'd40;
    localparam logic [15:0] SNOW_MIN   = 16'd20;
    localparam logic [15:0] WATER_MIN  = 16'd20;
    localparam logic [19:0] ICE_GAIN   = 20'd5;
    localparam logic [19:0] SNOW_GAIN  = 20'd12;
    localparam logic [19:0] WATER_GAIN = 20'd3;
    localparam logic [19:0] ICE_FULL   = 20'd4096;
    localparam logic [19:0] WATER_FULL = 20'd8192;

    localparam logic [15:0] DEN_M1_4K = 16'd4095;
    localparam logic [15:0] DEN_M1_8K = 16'd8191;
    localparam logic [31:0] RCP_4K    = 32'(RCP_ONE / 64'd4096);
    localparam logic [31:0] RCP_8K    = 32'(RCP_ONE / 64'd8192);

    // Overlay colour end points
    localparam t_rgb ICE_LO   = '{8'd180, 8'd200, 8'd230};
    localparam t_rgb ICE_HI   = '{8'd250, 8'd250, 8'd255};
    localparam t_rgb SNOW_LO  = '{8'd220, 8'd220, 8'd230};
    localparam t_rgb SNOW_HI  = '{8'd255, 8'd255, 8'd255};
    localparam t_rgb WATER_LO = '{8'd60, 8'd160, 8'd230};
    localparam t_rgb WATER_HI = '{8'd20, 8'd60, 8'd140};

    localparam int TER_STOPS = 16;
    localparam int TER_SEGS  = TER_STOPS - 1;

    // Terrain stops; the final stop sits at full scale
    localparam logic [16:0] TER_POS [TER_STOPS] = '{
        17'd0,     17'd9830,  17'd16384, 17'd19661,
        17'd20972, 17'd23593, 17'd27525, 17'd32768,
        17'd38011, 17'd43254, 17'd47186, 17'd51118,
        17'd55050, 17'd58982, 17'd62259, 17'd65536
    };

    localparam t_rgb TER_RGB [TER_STOPS] = '{
        '{8'd10,  8'd30,  8'd60},  '{8'd15,  8'd50,  8'd90},
        '{8'd25,  8'd80,  8'd120}, '{8'd45,  8'd120, 8'd160},
        '{8'd200, 8'd180, 8'd140}, '{8'd160, 8'd180, 8'd100},
        '{8'd100, 8'd160, 8'd70},  '{8'd70,  8'd135, 8'd55},
        '{8'd55,  8'd110, 8'd45},  '{8'd75,  8'd95,  8'd55},
        '{8'd110, 8'd95,  8'd70},  '{8'd130, 8'd115, 8'd90},
        '{8'd150, 8'd140, 8'd125}, '{8'd180, 8'd175, 8'd170},
        '{8'd220, 8'd220, 8'd225}, '{8'd255, 8'd255, 8'd255}
    };

    localparam logic [15:0] TER_DEN_M1 [TER_SEGS] = '{
        16'd9829, 16'd6553, 16'd3276, 16'd1310, 16'd2620,
        16'd3931, 16'd5242, 16'd5242, 16'd5242, 16'd3931,
        16'd3931, 16'd3931, 16'd3931, 16'd3276, 16'd3276
    };

    // ceil(2^42 / span) for each terrain segment
    localparam logic [31:0] TER_RCP [TER_SEGS] = '{
        32'((RCP_ONE + 64'd9829) / 64'd9830),
        32'((RCP_ONE + 64'd6553) / 64'd6554),
        32'((RCP_ONE + 64'd3276) / 64'd3277),
        32'((RCP_ONE + 64'd1310) / 64'd1311),
        32'((RCP_ONE + 64'd2620) / 64'd2621),
        32'((RCP_ONE + 64'd3931) / 64'd3932),
        32'((RCP_ONE + 64'd5242) / 64'd5243),
        32'((RCP_ONE + 64'd5242) / 64'd5243),
        32'((RCP_ONE + 64'd5242) / 64'd5243),
        32'((RCP_ONE + 64'd3931) / 64'd3932),
        32'((RCP_ONE + 64'd3931) / 64'd3932),
        32'((RCP_ONE + 64'd3931) / 64'd3932),
        32'((RCP_ONE + 64'd3931) / 64'd3932),
        32'((RCP_ONE + 64'd3276) / 64'd3277),
        32'((RCP_ONE + 64'd3276) / 64'd3277)
    };

    // Grayscale: one segment over the full range
    localparam t_rgb        GRAY_LO  = '{8'd0, 8'd0, 8'd0};
    localparam t_rgb        GRAY_HI  = '{8'd255, 8'd255, 8'd255};
    localparam logic [31:0] GRAY_RCP = 32'(RCP_ONE / 64'd65536);

    // Elevation: two half-range segments
    localparam logic [15:0] ELEV_MID = 16'd32768;
    localparam t_rgb        ELEV_C0  = '{8'd0, 8'd100, 8'd0};
    localparam t_rgb        ELEV_C1  = '{8'd255, 8'd255, 8'd0};
    localparam t_rgb        ELEV_C2  = '{8'd255, 8'd0, 8'd0};
    localparam logic [31:0] ELEV_RCP = 32'(RCP_ONE / 64'd32768);

    // Segment holding h: the last stop strictly below h, else the first
    function automatic logic [3:0] seg_find(input logic [1:0] preset, input logic [15:0] h);
        logic [3:0] seg;
        seg = '0;
        unique case (preset)
            PRE_GRAY: seg = '0;
            PRE_ELEV: seg = (h > ELEV_MID) ? 4'd1 : 4'd0;
            default: begin
                for (int j = 1; j < TER_SEGS; j++) begin
                    if ({1'b0, h} > TER_POS[j]) begin
                        seg = 4'(j);
                    end
                end
            end
        endcase
        return seg;
    endfunction

    // Segment constants for a preset and segment number
    function automatic t_seg seg_info(input logic [1:0] preset, input logic [3:0] seg);
        t_seg s;
        unique case (preset)
            PRE_GRAY: begin
                s.lo_pos = '0;
                s.den_m1 = 16'hFFFF;
                s.rcp    = GRAY_RCP;
                s.lo     = GRAY_LO;
                s.hi     = GRAY_HI;
            end
            PRE_ELEV: begin
                s.lo_pos = seg[0] ? ELEV_MID : 16'd0;
                s.den_m1 = ELEV_MID - 16'd1;
                s.rcp    = ELEV_RCP;
                s.lo     = seg[0] ? ELEV_C1 : ELEV_C0;
                s.hi     = seg[0] ? ELEV_C2 : ELEV_C1;
            end
            default: begin
                // segment numbers stop at 14, so the next stop index fits 4 bits
                s.lo_pos = TER_POS[seg][15:0];
                s.den_m1 = TER_DEN_M1[seg];
                s.rcp    = TER_RCP[seg];
                s.lo     = TER_RGB[seg];
                s.hi     = TER_RGB[seg + 4'd1];
            end
        endcase
        return s;
    endfunction

endpackage

/* rtl/hcr_lane.sv */
// One colour channel: scaled product, reciprocal multiply, final add or subtract
module hcr_lane import hcr_pkg::*; (
    input  logic              i_clk,
    input  t_lane_en          i_en,
    input  logic [CHAN_W-1:0] i_a,
    input  logic [CHAN_W-1:0] i_diff,
    input  logic              i_desc,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [NUM_W-1:0]  i_den_m1,
    input  logic [RCP_W-1:0]  i_rcp,
    output logic [CHAN_W-1:0] o_chan
);

    logic [PROD_W-1:0] r_p;
    logic [RCP_W-1:0]  r_rcp;
    logic [CHAN_W-1:0] r_a3;
    logic              r_desc3;
    logic [CHAN_W-1:0] r_q;
    logic [CHAN_W-1:0] r_a4;
    logic              r_desc4;
    logic [CHAN_W-1:0] r_chan;

    logic [PROD_W-1:0] n_p;
    logic [MUL_W-1:0]  n_prod;
    logic [CHAN_W-1:0] n_chan;

    // Stage 3: diff * num, biased by span-1 so the step of a falling ramp rounds up
    assign n_p = PROD_W'(i_diff) * PROD_W'(i_num)
               + (i_desc ? PROD_W'(i_den_m1) : PROD_W'(0));

    // Stage 4: divide by span through its reciprocal
    assign n_prod = MUL_W'(r_p) * MUL_W'(r_rcp);

    // Stage 5: step from the start colour
    assign n_chan = r_desc4 ? (r_a4 - r_q) : (r_a4 + r_q);

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r_p     <= n_p;
            r_rcp   <= i_rcp;
            r_a3    <= i_a;
            r_desc3 <= i_desc;
        end
        if (i_en.ld4) begin
            r_q     <= n_prod[RCP_SHIFT +: CHAN_W];
            r_a4    <= r_a3;
            r_desc4 <= r_desc3;
        end
        if (i_en.ld5) begin
            r_chan  <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

/* rtl/height_color_ramp_with_overlays.sv */
// Each cell passes through the stage registers 1 to 5, in order, before its result is shown.
// Throughput: one cell per cycle while the output is not stalled; each of the five stages takes
// a new cell whenever it is empty or its successor moves on, so gaps close up and an output stall
// only holds the full stages. Division is one reciprocal multiply per channel in stage 4.
// Reset (synchronous, active low) empties all stages and sets the terrain palette.
module height_color_ramp_with_overlays import hcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    logic [1:0] r_preset;

    // Stage valid bits and load enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic ld1, ld2, ld3, ld4, ld5;
    t_lane_en lane_en;

    // Stage 1 registers
    t_cls        r_cls_s1;
    logic [13:0] r_m_s1;
    logic [3:0]  r_seg_s1;
    logic [15:0] r_h_s1;
    logic [1:0]  r_preset_s1;

    // Stage 2 registers
    t_rgb        r_a_s2;
    t_rgb        r_diff_s2;
    logic [2:0]  r_desc_s2;
    logic [15:0] r_num_s2;
    logic [15:0] r_den_m1_s2;
    logic [31:0] r_rcp_s2;

    // Stage 1 next values
    t_cls        n_cls_s1;
    logic [13:0] n_m_s1;
    logic [19:0] ice_p, snow_p, water_p;

    // Stage 2 next values
    t_seg        seg;
    t_rgb        n_lo_s2, n_hi_s2, n_a_s2, n_diff_s2;
    logic [2:0]  n_desc_s2;
    logic [15:0] n_num_s2, n_den_m1_s2;
    logic [31:0] n_rcp_s2;

    t_rgb        chan;

    // Stage enables: a stage loads when empty or when its successor loads
    assign ld5 = !r_v5 || i_out_ready;
    assign ld4 = !r_v4 || ld5;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign o_in_ready = ld1;
    assign lane_en = '{ld3: ld3, ld4: ld4, ld5: ld5};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_preset <= PRE_TERRAIN;
        end else begin
            if (ld1) r_v1 <= i_in_valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ld5) r_v5 <= r_v4;
            if (i_cfg_we) r_preset <= i_cfg_data;
        end
    end

    // Stage 1: classify, clamp overlay intensity, locate terrain segment
    always_comb begin
        ice_p    = 20'(i_in_data.ice_thickness) * ICE_GAIN;
        snow_p   = 20'(i_in_data.snow_depth) * SNOW_GAIN;
        water_p  = 20'(i_in_data.water_depth) * WATER_GAIN;
        n_cls_s1 = CLS_TERRAIN;
        n_m_s1   = '0;
        priority if (i_in_data.ice_thickness > ICE_MIN) begin
            n_cls_s1 = CLS_ICE;
            n_m_s1   = (ice_p > ICE_FULL) ? 14'(ICE_FULL) : 14'(ice_p);
        end else if (i_in_data.snow_depth > SNOW_MIN) begin
            n_cls_s1 = CLS_SNOW;
            n_m_s1   = (snow_p > ICE_FULL) ? 14'(ICE_FULL) : 14'(snow_p);
        end else if (i_in_data.water_depth > WATER_MIN) begin
            n_cls_s1 = CLS_WATER;
            n_m_s1   = (water_p > WATER_FULL) ? 14'(WATER_FULL) : 14'(water_p);
        end else begin
            n_cls_s1 = CLS_TERRAIN;
            n_m_s1   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_cls_s1    <= n_cls_s1;
            r_m_s1      <= n_m_s1;
            r_seg_s1    <= seg_find(r_preset, i_in_data.height);
            r_h_s1      <= i_in_data.height;
            r_preset_s1 <= r_preset;
        end
    end

    // Stage 2: pick end colours, numerator, span and reciprocal
    always_comb begin
        seg = seg_info(r_preset_s1, r_seg_s1);
        unique case (r_cls_s1)
            CLS_ICE: begin
                n_lo_s2 = ICE_LO;   n_hi_s2 = ICE_HI;
                n_num_s2 = 16'(r_m_s1); n_den_m1_s2 = DEN_M1_4K; n_rcp_s2 = RCP_4K;
            end
            CLS_SNOW: begin
                n_lo_s2 = SNOW_LO;  n_hi_s2 = SNOW_HI;
                n_num_s2 = 16'(r_m_s1); n_den_m1_s2 = DEN_M1_4K; n_rcp_s2 = RCP_4K;
            end
            CLS_WATER: begin
                n_lo_s2 = WATER_LO; n_hi_s2 = WATER_HI;
                n_num_s2 = 16'(r_m_s1); n_den_m1_s2 = DEN_M1_8K; n_rcp_s2 = RCP_8K;
            end
            default: begin
                n_lo_s2 = seg.lo;   n_hi_s2 = seg.hi;
                n_num_s2 = r_h_s1 - seg.lo_pos;
                n_den_m1_s2 = seg.den_m1; n_rcp_s2 = seg.rcp;
            end
        endcase
        for (int c = 0; c < 3; c++) begin
            n_a_s2[c]    = n_lo_s2[c];
            n_desc_s2[c] = n_hi_s2[c] < n_lo_s2[c];
            n_diff_s2[c] = n_desc_s2[c] ? (n_lo_s2[c] - n_hi_s2[c])
                                        : (n_hi_s2[c] - n_lo_s2[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_a_s2      <= n_a_s2;
            r_diff_s2   <= n_diff_s2;
            r_desc_s2   <= n_desc_s2;
            r_num_s2    <= n_num_s2;
            r_den_m1_s2 <= n_den_m1_s2;
            r_rcp_s2    <= n_rcp_s2;
        end
    end

    // Stages 3 to 5, one lane per colour channel
    for (genvar c = 0; c < 3; c++) begin : g_lane
        hcr_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (lane_en),
            .i_a      (r_a_s2[c]),
            .i_diff   (r_diff_s2[c]),
            .i_desc   (r_desc_s2[c]),
            .i_num    (r_num_s2),
            .i_den_m1 (r_den_m1_s2),
            .i_rcp    (r_rcp_s2),
            .o_chan   (chan[c])
        );
    end

    assign o_out_valid = r_v5;
    assign o_out_data  = '{red: chan[0], green: chan[1], blue: chan[2], alpha: 8'hFF};

    // Input side only stalls when the result register is full and held
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a held result");

    // Grayscale terrain has a single segment
    a_gray_one_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_cls_s1 == CLS_TERRAIN && r_preset_s1 == PRE_GRAY) |-> (r_seg_s1 == 4'd0))
        else $error("grayscale segment out of range");

    // Elevation terrain never goes past its second segment
    a_elev_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_preset_s1 == PRE_ELEV) |-> (r_seg_s1 == 4'd0 || r_seg_s1 == 4'd1))
        else $error("elevation segment out of range");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

/* bench/hcr_colour_check.sv */
`timescale 1ns / 100ps

// Watches both channels and the palette port, predicts each colour and compares
module hcr_colour_check import hcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_outstanding
);

    // One ramp stop: position in Q1.16 (full scale is 65536) and its colour
    typedef struct packed {
        logic [16:0] pos;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } t_colour_stop;

    localparam t_colour_stop TERRAIN_STOPS [16] = '{
        '{17'd0,     8'd10,  8'd30,  8'd60},
        '{17'd9830,  8'd15,  8'd50,  8'd90},
        '{17'd16384, 8'd25,  8'd80,  8'd120},
        '{17'd19661, 8'd45,  8'd120, 8'd160},
        '{17'd20972, 8'd200, 8'd180, 8'd140},
        '{17'd23593, 8'd160, 8'd180, 8'd100},
        '{17'd27525, 8'd100, 8'd160, 8'd70},
        '{17'd32768, 8'd70,  8'd135, 8'd55},
        '{17'd38011, 8'd55,  8'd110, 8'd45},
        '{17'd43254, 8'd75,  8'd95,  8'd55},
        '{17'd47186, 8'd110, 8'd95,  8'd70},
        '{17'd51118, 8'd130, 8'd115, 8'd90},
        '{17'd55050, 8'd150, 8'd140, 8'd125},
        '{17'd58982, 8'd180, 8'd175, 8'd170},
        '{17'd62259, 8'd220, 8'd220, 8'd225},
        '{17'd65536, 8'd255, 8'd255, 8'd255}
    };

    localparam t_colour_stop GRAY_STOPS [2] = '{
        '{17'd0,     8'd0,   8'd0,   8'd0},
        '{17'd65536, 8'd255, 8'd255, 8'd255}
    };

    localparam t_colour_stop ELEV_STOPS [3] = '{
        '{17'd0,     8'd0,   8'd100, 8'd0},
        '{17'd32768, 8'd255, 8'd255, 8'd0},
        '{17'd65536, 8'd255, 8'd0,   8'd0}
    };

    // Overlay thresholds, gains and full-intensity points (Q4.12 depths)
    localparam int ICE_LIMIT   = 40;
    localparam int SNOW_LIMIT  = 20;
    localparam int WATER_LIMIT = 20;
    localparam int ICE_SCALE   = 5;
    localparam int SNOW_SCALE  = 12;
    localparam int WATER_SCALE = 3;
    localparam int SHADE_FULL  = 4096;
    localparam int DEPTH_FULL  = 8192;

    t_out_item  colour_q [$];
    logic [1:0] palette = PRE_TERRAIN;
    int         mismatches = 0;

    // Blend a + (b - a) * num / den, rounded down either way
    function automatic int ramp(input int a, input int b, input int num, input int den);
        if (b >= a)
            return a + (b - a) * num / den;
        return a - ((a - b) * num + den - 1) / den;
    endfunction

    // Terrain colour from the stop table chosen by the palette
    function automatic t_out_item ground_colour(input logic [1:0] sel, input logic [15:0] h);
        t_colour_stop tab [16];
        int           cnt;
        t_out_item    c;
        int           num;
        int           den;
        cnt = 16;
        for (int k = 0; k < 16; k++) tab[k] = TERRAIN_STOPS[k];
        case (sel)
            PRE_GRAY: begin
                tab[0] = GRAY_STOPS[0];
                tab[1] = GRAY_STOPS[1];
                cnt    = 2;
            end
            PRE_ELEV: begin
                for (int k = 0; k < 3; k++) tab[k] = ELEV_STOPS[k];
                cnt = 3;
            end
            default: ;  // terrain, also for the spare selector code
        endcase
        // beyond the final stop its colour holds
        c.red   = tab[cnt-1].r;
        c.green = tab[cnt-1].g;
        c.blue  = tab[cnt-1].b;
        c.alpha = 8'd255;
        for (int i = 0; i + 1 < cnt; i++) begin
            if ({1'b0, h} >= tab[i].pos && {1'b0, h} <= tab[i+1].pos) begin
                num     = h - tab[i].pos;
                den     = tab[i+1].pos - tab[i].pos;
                c.red   = 8'(ramp(tab[i].r, tab[i+1].r, num, den));
                c.green = 8'(ramp(tab[i].g, tab[i+1].g, num, den));
                c.blue  = 8'(ramp(tab[i].b, tab[i+1].b, num, den));
                return c;
            end
        end
        return c;
    endfunction

    // Full cell colour: ice over snow over water over terrain
    function automatic t_out_item cell_colour(input t_in_item in_cell, input logic [1:0] sel);
        t_out_item c;
        int        m;
        c.alpha = 8'd255;
        if (in_cell.ice_thickness > ICE_LIMIT) begin
            m       = int'(in_cell.ice_thickness) * ICE_SCALE;
            m       = (m > SHADE_FULL) ? SHADE_FULL : m;
            c.red   = 8'(ramp(180, 250, m, SHADE_FULL));
            c.green = 8'(ramp(200, 250, m, SHADE_FULL));
            c.blue  = 8'(ramp(230, 255, m, SHADE_FULL));
        end else if (in_cell.snow_depth > SNOW_LIMIT) begin
            m       = int'(in_cell.snow_depth) * SNOW_SCALE;
            m       = (m > SHADE_FULL) ? SHADE_FULL : m;
            c.red   = 8'(ramp(220, 255, m, SHADE_FULL));
            c.green = c.red;
            c.blue  = 8'(ramp(230, 255, m, SHADE_FULL));
        end else if (in_cell.water_depth > WATER_LIMIT) begin
            m       = int'(in_cell.water_depth) * WATER_SCALE;
            m       = (m > DEPTH_FULL) ? DEPTH_FULL : m;
            c.red   = 8'(ramp(60, 20, m, DEPTH_FULL));
            c.green = 8'(ramp(160, 60, m, DEPTH_FULL));
            c.blue  = 8'(ramp(230, 140, m, DEPTH_FULL));
        end else begin
            c = ground_colour(sel, in_cell.height);
        end
        return c;
    endfunction

    function automatic string chan_label(input int k);
        case (k)
            0: return "red";
            1: return "green";
            2: return "blue";
            default: return "alpha";
        endcase
    endfunction

    // Compare before queuing: a result never belongs to a cell taken at the same edge
    always @(posedge i_clk) begin : watch
        t_out_item want;
        logic [7:0] w8;
        logic [7:0] g8;
        if (!i_rst_n) begin
            palette = PRE_TERRAIN;
            colour_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (colour_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: colour with none expected, actual %0d %0d %0d %0d",
                             $time, i_out_data.red, i_out_data.green,
                             i_out_data.blue, i_out_data.alpha);
                end else begin
                    want = colour_q.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        w8 = want[31-8*k -: 8];
                        g8 = i_out_data[31-8*k -: 8];
                        if (g8 !== w8) begin
                            mismatches++;
                            $display("%0t: %s mismatch, expected %0d actual %0d",
                                     $time, chan_label(k), w8, g8);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                colour_q.insert(colour_q.size(), cell_colour(i_in_data, palette));
            // palette takes effect for cells after this edge
            if (i_cfg_we)
                palette = i_cfg_data;
        end
        o_outstanding <= colour_q.size();
        o_fail_count  <= mismatches;
    end

endmodule

/* bench/tb_height_color_ramp_with_overlays.sv */
`timescale 1ns / 100ps

module tb_height_color_ramp_with_overlays;
    import hcr_pkg::*;

    localparam int CELLS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 6;
    localparam int LONG_HOLD       = 120;
    localparam int SETTLE_CYCLES   = 12;
    localparam int STALL_LIMIT     = 5000;

    // selector code with no table of its own
    localparam logic [1:0] PRE_SPARE = 2'd3;

    // stop positions, some with their neighbours, plus the range ends
    localparam logic [15:0] PROBE_HEIGHTS [22] = '{
        16'd0,     16'd1,     16'd9829,  16'd9830,  16'd9831,  16'd16384,
        16'd19661, 16'd20972, 16'd23593, 16'd27525, 16'd32767, 16'd32768,
        16'd32769, 16'd38011, 16'd43254, 16'd47186, 16'd51118, 16'd55050,
        16'd58982, 16'd62259, 16'd65534, 16'd65535
    };

    localparam logic [1:0] PHASE_PALETTE [NUM_PHASES] = '{
        PRE_SPARE, PRE_GRAY, PRE_ELEV, PRE_TERRAIN, PRE_ELEV, PRE_GRAY
    };
    localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{0, 30, 50, 20, 70, 10};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    int idle_pct = 0;
    bit hold_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    height_color_ramp_with_overlays dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    hcr_colour_check checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [15:0] pick_height();
        if ($urandom_range(3) == 0)
            return PROBE_HEIGHTS[5'($urandom_range(21))];
        return 16'($urandom_range(65535));
    endfunction

    // Depth above a threshold: just over it, around saturation, or anywhere
    function automatic logic [15:0] deep(input int lo, input int sat);
        case ($urandom_range(3))
            0: return 16'(lo + 1 + $urandom_range(3));
            1: return 16'(sat - 2 + $urandom_range(4));
            default: return 16'($urandom_range(65535, lo + 1));
        endcase
    endfunction

    function automatic t_in_item pack_cell(input logic [15:0] h, input logic [15:0] water,
                                           input logic [15:0] ice, input logic [15:0] snow);
        t_in_item c;
        c.height        = h;
        c.water_depth   = water;
        c.ice_thickness = ice;
        c.snow_depth    = snow;
        return c;
    endfunction

    // Random cell, weighted towards terrain; overlays below threshold stay live
    function automatic t_in_item make_cell();
        t_in_item c;
        c = pack_cell(pick_height(), 16'($urandom_range(20)), 16'($urandom_range(40)),
                      16'($urandom_range(20)));
        case ($urandom_range(7))
            0: begin
                c.ice_thickness = deep(40, 820);
                c.snow_depth    = 16'($urandom_range(65535));
                c.water_depth   = 16'($urandom_range(65535));
            end
            1: begin
                c.snow_depth  = deep(20, 342);
                c.water_depth = 16'($urandom_range(65535));
            end
            2: c.water_depth = deep(20, 2731);
            default: ;
        endcase
        return c;
    endfunction

    // Offer one cell and wait for its transaction; valid stays high afterwards
    task automatic send_cell(input t_in_item c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait for every colour to come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_palette(input logic [1:0] sel);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= sel;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Receiver: random back-pressure, or one long hold-off on request
    initial begin : rx_side
        int n;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    out_ready <= 1'b1;
                end else begin
                    out_ready <= 1'b0;
                    repeat (n - 1) @(posedge clk);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cells on the reset palette: range ends, stops, thresholds,
        // saturation and priority between overlays
        send_cell(pack_cell(16'd0,     16'd0,     16'd0,     16'd0));
        send_cell(pack_cell(16'd65535, 16'd0,     16'd0,     16'd0));
        send_cell(pack_cell(16'd9830,  16'd0,     16'd0,     16'd0));
        send_cell(pack_cell(16'd20972, 16'd20,    16'd40,    16'd20));
        send_cell(pack_cell(16'd32768, 16'd0,     16'd0,     16'd0));
        send_cell(pack_cell(16'd1000,  16'd0,     16'd41,    16'd0));
        send_cell(pack_cell(16'd1000,  16'd0,     16'd819,   16'd0));
        send_cell(pack_cell(16'd1000,  16'd0,     16'd820,   16'd0));
        send_cell(pack_cell(16'd1000,  16'd0,     16'd65535, 16'd0));
        send_cell(pack_cell(16'd5000,  16'd0,     16'd0,     16'd21));
        send_cell(pack_cell(16'd5000,  16'd0,     16'd0,     16'd341));
        send_cell(pack_cell(16'd5000,  16'd0,     16'd0,     16'd342));
        send_cell(pack_cell(16'd5000,  16'd0,     16'd0,     16'd65535));
        send_cell(pack_cell(16'd7000,  16'd21,    16'd0,     16'd0));
        send_cell(pack_cell(16'd7000,  16'd2730,  16'd0,     16'd0));
        send_cell(pack_cell(16'd7000,  16'd2731,  16'd0,     16'd0));
        send_cell(pack_cell(16'd7000,  16'd65535, 16'd0,     16'd0));
        send_cell(pack_cell(16'd40000, 16'd65535, 16'd65535, 16'd65535));
        send_cell(pack_cell(16'd40000, 16'd65535, 16'd0,     16'd65535));
        send_cell(pack_cell(16'd62259, 16'd65535, 16'd40,    16'd20));
        send_cell(pack_cell(16'd65535, 16'd65535, 16'd65535, 16'd65535));

        // Random phases, one palette each, idle levels varying
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_palette(PHASE_PALETTE[ph]);
            idle_pct = PHASE_IDLE_PCT[ph];
            if (ph == 1)
                hold_req = 1'b1;   // pipeline fills and input stalls
            for (int n = 0; n < CELLS_PER_PHASE; n++) begin
                send_cell(make_cell());
                if (ph == 3 && n == CELLS_PER_PHASE / 2)
                    settle();
            end
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
